// ===== rtl/lpht_pkg.sv =====
package lpht_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = 7;
  localparam int KEY_BYTES = 8;

  localparam logic [1:0] KIND_SET = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_DEL = 2'd2;

  localparam logic [1:0] ST_NEW  = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] key;
    logic [3:0]  key_len;
    logic [31:0] hash;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
  } rsp_t;

  // Masks key bytes beyond the length; lengths above KEY_BYTES keep all bytes.
  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (4'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/lpht_front.sv =====
module lpht_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  lpht_pkg::req_t in_req,
  output logic          q_valid,
  output lpht_pkg::req_t q_req,
  input  logic          q_pop
);

  // Two-entry queue; requests are normalized (key masked) on entry.
  lpht_pkg::req_t mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  lpht_pkg::req_t norm;
  logic push;

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_req = mem_r[rp_r];

  always_comb begin
    norm = in_req;
    norm.key = in_req.key & lpht_pkg::key_mask(in_req.key_len);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= norm;
    end
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ===== rtl/lpht_back.sv =====
module lpht_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  lpht_pkg::req_t           q_req,
  output logic                     q_pop,
  input  logic [lpht_pkg::CNT_W-1:0] load_limit,
  output logic                     out_valid,
  output lpht_pkg::rsp_t           out_rsp
);

  localparam int IW = lpht_pkg::IDX_W;
  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_CMP = 3'd2, S_DONE = 3'd3;
  localparam logic [2:0] S_CLR = 3'd4;

  // Marks live in a memory with registered read; a clearing pass after reset
  // walks every slot once and marks it empty.
  logic [1:0] mark_mem [lpht_pkg::CAPACITY];
  logic [1:0] mark_rd_r;
  // Slot payload lives in a memory with registered read and a separate write port.
  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  len;
    logic [31:0] hash;
    logic [31:0] value;
  } slot_t;
  slot_t slot_mem [lpht_pkg::CAPACITY];
  slot_t rd_r;

  logic [2:0]    st_r, st_nxt;
  logic [IW-1:0] idx_r, tomb_at_r, hit_at_r, empty_at_r;
  logic [IW:0]   steps_r;
  logic          tomb_r, hit_r, empty_r;
  logic [lpht_pkg::CNT_W-1:0] occ_r;
  logic          match;
  logic          wr_en;
  logic [IW-1:0] wr_at;
  slot_t         wr_d;
  logic [1:0]    wr_mark;
  logic [1:0]    status;
  logic [31:0]   rv;
  logic          occ_inc;

  assign match = (rd_r.len == q_req.key_len) && (rd_r.hash == q_req.hash) &&
                 (rd_r.key == q_req.key);

  always_comb begin
    status = lpht_pkg::ST_MISS;
    rv = '0;
    wr_en = 1'b0;
    wr_at = hit_at_r;
    wr_d = '{key: q_req.key, len: q_req.key_len, hash: q_req.hash, value: q_req.value};
    wr_mark = lpht_pkg::MARK_USED;
    occ_inc = 1'b0;
    case (q_req.kind)
      lpht_pkg::KIND_SET: begin
        if (hit_r) begin
          wr_en = 1'b1;
          wr_d = '{key: rd_r.key, len: rd_r.len, hash: rd_r.hash, value: q_req.value};
          status = lpht_pkg::ST_OK;
        end else if (tomb_r) begin
          wr_en = 1'b1;
          wr_at = tomb_at_r;
          status = lpht_pkg::ST_NEW;
        end else if (empty_r && ({1'b0, occ_r} + 8'd1 <= {1'b0, load_limit})) begin
          wr_en = 1'b1;
          wr_at = empty_at_r;
          occ_inc = 1'b1;
          status = lpht_pkg::ST_NEW;
        end else begin
          status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::KIND_GET: begin
        if (hit_r) begin
          status = lpht_pkg::ST_OK;
          rv = rd_r.value;
        end
      end
      lpht_pkg::KIND_DEL: begin
        if (hit_r) begin
          wr_en = 1'b1;
          wr_mark = lpht_pkg::MARK_TOMB;
          wr_d = '{key: rd_r.key, len: 4'd0, hash: rd_r.hash, value: 32'd0};
          status = lpht_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_CLR: if (idx_r == IW'(lpht_pkg::CAPACITY - 1)) st_nxt = S_IDLE;
      S_IDLE: if (q_valid) st_nxt = S_READ;
      S_READ: begin
        if (steps_r == (IW+1)'(lpht_pkg::CAPACITY)) st_nxt = S_DONE;
        else st_nxt = S_CMP;
      end
      S_CMP: begin
        if (mark_rd_r == lpht_pkg::MARK_EMPTY) st_nxt = S_DONE;
        else if (mark_rd_r == lpht_pkg::MARK_TOMB) st_nxt = S_READ;
        else if (match) st_nxt = S_DONE;
        else st_nxt = S_READ;
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign q_pop = (st_r == S_DONE);

  always_ff @(posedge clk) begin
    rd_r <= slot_mem[idx_r];
    mark_rd_r <= mark_mem[idx_r];
    if (st_r == S_DONE && wr_en) begin
      slot_mem[wr_at] <= wr_d;
    end
    if (st_r == S_CLR) begin
      mark_mem[idx_r] <= lpht_pkg::MARK_EMPTY;
    end else if (st_r == S_DONE && wr_en) begin
      mark_mem[wr_at] <= wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp <= '{status: status, read_value: rv};
    if (!rst_n) begin
      st_r <= S_CLR;
      idx_r <= '0;
      occ_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= (st_r == S_DONE);
      case (st_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
        end
        S_IDLE: begin
          idx_r <= q_req.hash[IW-1:0];
          steps_r <= '0;
          hit_r <= 1'b0;
          tomb_r <= 1'b0;
          empty_r <= 1'b0;
        end
        S_CMP: begin
          if (mark_rd_r == lpht_pkg::MARK_EMPTY) begin
            empty_r <= 1'b1;
            empty_at_r <= idx_r;
          end else if (mark_rd_r == lpht_pkg::MARK_TOMB) begin
            if (!tomb_r) begin
              tomb_r <= 1'b1;
              tomb_at_r <= idx_r;
            end
            idx_r <= idx_r + 1'b1;
            steps_r <= steps_r + 1'b1;
          end else if (match) begin
            hit_r <= 1'b1;
            hit_at_r <= idx_r;
          end else begin
            idx_r <= idx_r + 1'b1;
            steps_r <= steps_r + 1'b1;
          end
        end
        S_DONE: begin
          if (occ_inc) occ_r <= occ_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing and tombstones.
// Input channel: a transaction (set, get or delete) is taken at a rising edge
// where start is high and busy is low. The request carries the key, its
// length, a precomputed hash and a value for set.
// Configuration: cfg_we writes cfg_wdata into the load limit, which resets
// to 48. Write it only while the table is idle.
// Result channel: each request yields exactly one result, shown for one
// cycle with out_valid high. The receiver cannot stall the result.
// A front stage masks the key and holds up to two requests in a queue; busy
// rises only when that queue is full. The back stage walks the slots one at
// a time from hash mod 64, for at most a full lap of 64 slots. Each slot
// takes a READ state (registered mark and payload read), then a CMP state
// (the decision). A settled request ends in the DONE state, and the result
// strobe, registered from it, appears in the cycle after. The back stage
// handles requests one at a time, the next only once the last is retired.
// After reset a clearing pass marks every slot empty; requests accepted
// meanwhile wait in the queue. Reset also clears the occupancy count.
module linear_probe_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lpht_pkg::req_t             in_req,
  output logic                       out_valid,
  output lpht_pkg::rsp_t             out_rsp,
  input  logic                       cfg_we,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata
);

  logic                       q_valid, q_pop;
  lpht_pkg::req_t             q_req;
  logic [lpht_pkg::CNT_W-1:0] load_limit_r;

  // The load limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_limit_r <= lpht_pkg::CNT_W'(48);
    end else if (cfg_we) begin
      load_limit_r <= cfg_wdata;
    end
  end

  lpht_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop)
  );

  lpht_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_req(q_req), .q_pop(q_pop),
    .load_limit(load_limit_r), .out_valid(out_valid), .out_rsp(out_rsp)
  );

  // The back stage only retires a transaction the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  // Every retirement produces a result on the next cycle.
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid) else $error("result missing after retire");
  // A result appears only after a retirement.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(q_pop)) else $error("spurious result");

endmodule
